>>> sv/porc_pkg.sv
// Shared types, selector codes and post-divider table for the PLL output rate calculator.
package porc_pkg;

    typedef struct packed {
        logic [4:0]  output_select;
        logic [31:0] parent_rate;
        logic [31:0] base_word;
        logic [31:0] misc_word;
        logic [31:0] divider_word;
    } in_word_t;

    typedef struct packed {
        logic [39:0] output_rate;
        logic        divide_error;
    } out_word_t;

    // Controls carried alongside the first divider
    typedef struct packed {
        logic [7:0] mul_n;
        logic [7:0] div2;
        logic [4:0] shift;
        logic       zero;
        logic       err;
    } ctl1_t;

    // Controls carried alongside the second divider
    typedef struct packed {
        logic [4:0] shift;
        logic       zero;
        logic       err;
    } ctl2_t;

    localparam int unsigned OUT_BITS = 40;

    localparam logic [4:0] SEL_BASE0   = 5'd0;
    localparam logic [4:0] SEL_DIVB1   = 5'd1;
    localparam logic [4:0] SEL_BASE2   = 5'd2;
    localparam logic [4:0] SEL_BASE3   = 5'd3;
    localparam logic [4:0] SEL_BASE4   = 5'd4;
    localparam logic [4:0] SEL_BASE5   = 5'd5;
    localparam logic [4:0] SEL_DIVM6   = 5'd6;
    localparam logic [4:0] SEL_VCO7    = 5'd7;
    localparam logic [4:0] SEL_DIVM8   = 5'd8;
    localparam logic [4:0] SEL_SHIFT9  = 5'd9;
    localparam logic [4:0] SEL_DIVM10  = 5'd10;
    localparam logic [4:0] SEL_DIVH11  = 5'd11;
    localparam logic [4:0] SEL_DIVH12  = 5'd12;
    localparam logic [4:0] SEL_PLLE13  = 5'd13;
    localparam logic [4:0] SEL_PLLEP14 = 5'd14;
    localparam logic [4:0] SEL_DIVB15  = 5'd15;
    localparam logic [4:0] SEL_C4VCO16 = 5'd16;
    localparam logic [4:0] SEL_C4P17   = 5'd17;
    localparam logic [4:0] SEL_THIRD18 = 5'd18;
    localparam logic [4:0] SEL_FIFTH19 = 5'd19;
    localparam logic [4:0] SEL_DIVB20  = 5'd20;

    // Post-divider table indexed by the P field
    function automatic logic [7:0] post_div(input logic [4:0] p);
        logic [7:0] d;
        case (p)
            5'd0:    d = 8'd1;
            5'd1:    d = 8'd2;
            5'd2:    d = 8'd3;
            5'd3:    d = 8'd4;
            5'd4:    d = 8'd5;
            5'd5:    d = 8'd6;
            5'd6:    d = 8'd8;
            5'd7:    d = 8'd10;
            5'd8:    d = 8'd12;
            5'd9:    d = 8'd16;
            5'd10:   d = 8'd12;
            5'd11:   d = 8'd16;
            5'd12:   d = 8'd20;
            5'd13:   d = 8'd24;
            5'd14:   d = 8'd32;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

endpackage

>>> sv/porc_div.sv
// Pipelined restoring divider: wide dividend by an 8-bit divisor, K quotient bits per stage.
module porc_div
    import porc_pkg::*;
#(
    parameter int unsigned W  = 32,
    parameter int unsigned K  = 4,
    parameter int unsigned SW = 8
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  logic [W-1:0]  in_num,
    input  logic [7:0]    in_dvs,
    input  logic [SW-1:0] in_side,
    output logic          out_vld,
    output logic [W-1:0]  out_quo,
    output logic [SW-1:0] out_side
);

    localparam int unsigned STG = (W + K - 1) / K;
    localparam int unsigned WP  = STG * K;

    logic          vld_reg  [STG];
    logic [WP-1:0] num_reg  [STG];
    logic [7:0]    rem_reg  [STG];
    logic [7:0]    dvs_reg  [STG];
    logic [SW-1:0] side_reg [STG];

    for (genvar s = 0; s < STG; s++)
    begin : g_stage
        logic          src_vld;
        logic [WP-1:0] src_num;
        logic [7:0]    src_rem;
        logic [7:0]    src_dvs;
        logic [SW-1:0] src_side;
        logic [WP-1:0] num_next;
        logic [7:0]    rem_next;

        if (s == 0)
        begin : g_first
            assign src_vld  = in_vld;
            assign src_num  = WP'(in_num);
            assign src_rem  = 8'd0;
            assign src_dvs  = in_dvs;
            assign src_side = in_side;
        end
        else
        begin : g_rest
            assign src_vld  = vld_reg[s-1];
            assign src_num  = num_reg[s-1];
            assign src_rem  = rem_reg[s-1];
            assign src_dvs  = dvs_reg[s-1];
            assign src_side = side_reg[s-1];
        end

        // Shift in K dividend bits, subtract where the divisor fits
        always_comb
        begin
            logic [WP-1:0] n;
            logic [8:0]    r;
            n = src_num;
            r = {1'b0, src_rem};
            for (int k = 0; k < K; k++)
            begin
                r = {r[7:0], n[WP-1]};
                n = {n[WP-2:0], 1'b0};
                if (r >= {1'b0, src_dvs})
                begin
                    r    = r - {1'b0, src_dvs};
                    n[0] = 1'b1;
                end
            end
            num_next = n;
            rem_next = r[7:0];
        end

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= src_vld;
        end

        // Advance the payload
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[s]  <= num_next;
                rem_reg[s]  <= rem_next;
                dvs_reg[s]  <= src_dvs;
                side_reg[s] <= src_side;
            end
        end
    end

    assign out_vld  = vld_reg[STG-1];
    assign out_quo  = num_reg[STG-1][W-1:0];
    assign out_side = side_reg[STG-1];

endmodule

>>> sv/pll_output_rate_calculator_core.sv
// Top level of the PLL output rate calculator: decode, two dividers, multiply, output stage.
//
//  channel | direction | handshake              | word
//  in      | input     | in_valid / in_ready    | in_word_t  (selector, parent, three registers)
//  out     | output    | out_valid / out_ready  | out_word_t (rate, divide error)
//
// One word enters per cycle when the output is free or being taken.
// Each word passes the decode register, the first divider, the multiply register, the second
// divider and the output register; both dividers retire four quotient bits per stage.
// A stall on out freezes every stage at once; nothing is dropped or repeated.
// Reset clears the valid bits only; the payload registers are not reset.
module pll_output_rate_calculator_core
    import porc_pkg::*;
#(
    parameter int unsigned RATE_BITS = 32
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    localparam int unsigned W  = RATE_BITS;
    localparam int unsigned W2 = RATE_BITS + 8;
    localparam int unsigned WX = W2 + OUT_BITS;

    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // ---------------- Decode stage ----------------
    logic [W+31:0] parent_wide;
    logic [W-1:0]  parent;
    logic [7:0]    m_fld;
    logic [7:0]    d1_next;
    ctl1_t         ctl_next;

    assign parent_wide = {{W{1'b0}}, in_word.parent_rate};
    assign parent      = parent_wide[W-1:0];
    assign m_fld       = in_word.base_word[7:0];

    always_comb
    begin
        logic [31:0] b;
        logic [31:0] mi;
        logic [31:0] dw;
        logic        use_m;
        b  = in_word.base_word;
        mi = in_word.misc_word;
        dw = in_word.divider_word;
        use_m          = 1'b0;
        d1_next        = 8'd1;
        ctl_next.mul_n = 8'd1;
        ctl_next.div2  = 8'd1;
        ctl_next.shift = 5'd0;
        ctl_next.zero  = 1'b0;
        ctl_next.err   = 1'b0;
        case (in_word.output_select) inside
            SEL_BASE0, SEL_BASE2, SEL_BASE3, SEL_BASE4, SEL_BASE5:
            begin
                if (!b[31])
                begin
                    use_m          = 1'b1;
                    ctl_next.mul_n = b[17:10];
                    ctl_next.div2  = post_div(b[24:20]);
                end
            end
            SEL_DIVB1, SEL_DIVB15, SEL_DIVB20:
                if (!dw[16]) d1_next = {1'b0, dw[15:9]} + 8'd1;
            SEL_DIVM6, SEL_DIVM8, SEL_DIVM10:
            begin
                if (!(((in_word.output_select == SEL_DIVM6) && mi[30]) ||
                      ((in_word.output_select == SEL_DIVM8) && mi[24]) ||
                      ((in_word.output_select == SEL_DIVM10) && mi[26])))
                    d1_next = {1'b0, dw[15:9]} + 8'd1;
            end
            SEL_DIVH11:
                if (!mi[27]) d1_next = {1'b0, dw[31:25]} + 8'd1;
            SEL_DIVH12:
                if (!mi[30]) d1_next = {1'b0, dw[31:25]} + 8'd1;
            SEL_VCO7:
            begin
                if (!b[31])
                begin
                    use_m          = 1'b1;
                    ctl_next.mul_n = b[17:10];
                end
            end
            SEL_SHIFT9:
                ctl_next.shift = b[24:20];
            SEL_PLLE13:
            begin
                use_m          = 1'b1;
                ctl_next.mul_n = b[15:8];
                ctl_next.shift = b[29] ? 5'd1 : 5'd2;
            end
            SEL_PLLEP14:
                ctl_next.div2 = post_div(b[28:24]);
            SEL_C4VCO16:
            begin
                if (!b[31])
                begin
                    use_m          = 1'b1;
                    ctl_next.mul_n = b[15:8];
                end
            end
            SEL_C4P17:
                ctl_next.div2 = post_div(b[23:19]);
            SEL_THIRD18:
                d1_next = 8'd3;
            SEL_FIFTH19:
                d1_next = 8'd5;
            default:
                ctl_next.zero = 1'b1;
        endcase
        // Drop to zero with an error when M is needed and missing
        if (use_m)
        begin
            if (m_fld == 8'd0)
            begin
                ctl_next.zero = 1'b1;
                ctl_next.err  = 1'b1;
            end
            else
                d1_next = m_fld;
        end
    end

    logic         dec_vld_reg;
    logic [W-1:0] dec_parent_reg;
    logic [7:0]   dec_d1_reg;
    ctl1_t        dec_ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dec_vld_reg <= 1'b0;
        else if (en)
            dec_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dec_parent_reg <= parent;
            dec_d1_reg     <= d1_next;
            dec_ctl_reg    <= ctl_next;
        end
    end

    // ---------------- First divider ----------------
    logic                d1_vld;
    logic [W-1:0]        d1_quo;
    logic [$bits(ctl1_t)-1:0] d1_side;
    ctl1_t               d1_ctl;

    porc_div #(.W(W), .K(4), .SW($bits(ctl1_t))) u_div1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (dec_vld_reg),
        .in_num   (dec_parent_reg),
        .in_dvs   (dec_d1_reg),
        .in_side  (dec_ctl_reg),
        .out_vld  (d1_vld),
        .out_quo  (d1_quo),
        .out_side (d1_side)
    );

    assign d1_ctl = ctl1_t'(d1_side);

    // ---------------- Multiply by N ----------------
    logic          mul_vld_reg;
    logic [W2-1:0] mul_prod_reg;
    logic [7:0]    mul_div2_reg;
    ctl2_t         mul_ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_vld_reg <= 1'b0;
        else if (en)
            mul_vld_reg <= d1_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_prod_reg      <= W2'(d1_quo) * W2'(d1_ctl.mul_n);
            mul_div2_reg      <= d1_ctl.div2;
            mul_ctl_reg.shift <= d1_ctl.shift;
            mul_ctl_reg.zero  <= d1_ctl.zero;
            mul_ctl_reg.err   <= d1_ctl.err;
        end
    end

    // ---------------- Second divider ----------------
    logic                d2_vld;
    logic [W2-1:0]       d2_quo;
    logic [$bits(ctl2_t)-1:0] d2_side;
    ctl2_t               d2_ctl;

    porc_div #(.W(W2), .K(4), .SW($bits(ctl2_t))) u_div2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (mul_vld_reg),
        .in_num   (mul_prod_reg),
        .in_dvs   (mul_div2_reg),
        .in_side  (mul_ctl_reg),
        .out_vld  (d2_vld),
        .out_quo  (d2_quo),
        .out_side (d2_side)
    );

    assign d2_ctl = ctl2_t'(d2_side);

    // ---------------- Output stage: shift, zero, saturate ----------------
    logic [WX-1:0]       shifted;
    logic [OUT_BITS-1:0] rate_next;

    assign shifted = WX'(d2_quo) >> d2_ctl.shift;

    always_comb
    begin
        if (d2_ctl.zero)
            rate_next = '0;
        else if (|shifted[WX-1:OUT_BITS])
            rate_next = '1;
        else
            rate_next = shifted[OUT_BITS-1:0];
    end

    logic      out_vld_reg;
    out_word_t out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= d2_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_word_reg.output_rate  <= rate_next;
            out_word_reg.divide_error <= d2_ctl.err;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_word  = out_word_reg;

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.divide_error |-> out_word.output_rate == '0)
        else $error("divide error with nonzero rate");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output empty");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(out_word) && out_valid)
        else $error("output changed during stall");

    a_err_cause: assert property (@(posedge clk) disable iff (!rst_n)
        d2_vld && d2_ctl.err |-> d2_ctl.zero)
        else $error("error flag without zero force");
`endif

endmodule

>>> dv/pll_output_rate_calculator_core_tb.sv
// Testbench for the PLL output rate calculator: random and directed queries checked against a local rate predictor.
module pll_output_rate_calculator_core_tb;
    import porc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_QUERIES = 1850;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 120;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_word;

    in_word_t  pending_queries[$];
    out_word_t expected_rates[$];
    int        mismatches;
    int        idle_cycles;
    bit        stimulus_done;
    int        send_gap;
    int        take_gap;
    int        hold_left;
    bit        hold_done;
    int        taken;
    bit        in_taken;

    pll_output_rate_calculator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always #10 clk = ~clk;

    // Post-divider table by P field
    function automatic logic [63:0] post_divisor(input logic [4:0] p);
        logic [7:0] tbl [0:14];
        tbl = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd8, 8'd10, 8'd12, 8'd16,
                8'd12, 8'd16, 8'd20, 8'd24, 8'd32};
        return (p < 5'd15) ? 64'(tbl[p]) : 64'd1;
    endfunction

    // Output rate of one query
    function automatic out_word_t predict_rate(input in_word_t q);
        logic [63:0] parent, rate, vco, m;
        logic [31:0] b, dw, mw;
        logic        err;
        logic        byp;
        int          dsh;
        out_word_t   r;
        parent = 64'(q.parent_rate);
        b = q.base_word;
        dw = q.divider_word;
        mw = q.misc_word;
        m = 64'(b[7:0]);
        err = 1'b0;
        rate = 0;
        vco = 0;
        byp = 1'b0;
        dsh = -1;
        case (q.output_select)
            SEL_BASE0, SEL_BASE2, SEL_BASE3, SEL_BASE4, SEL_BASE5, SEL_VCO7:
            begin
                if (b[31])
                    rate = parent;
                else if (m == 0)
                    err = 1'b1;
                else
                begin
                    vco = (parent / m) * 64'(b[17:10]);
                    rate = (q.output_select == SEL_VCO7) ? vco
                                                         : vco / post_divisor(b[24:20]);
                end
            end
            SEL_DIVB1, SEL_DIVB15, SEL_DIVB20: begin dsh = 8;  byp = dw[16]; end
            SEL_DIVM6:                         begin dsh = 8;  byp = mw[30]; end
            SEL_DIVM8:                         begin dsh = 8;  byp = mw[24]; end
            SEL_DIVM10:                        begin dsh = 8;  byp = mw[26]; end
            SEL_DIVH11:                        begin dsh = 24; byp = mw[27]; end
            SEL_DIVH12:                        begin dsh = 24; byp = mw[30]; end
            SEL_SHIFT9:  rate = parent >> b[24:20];
            SEL_PLLE13, SEL_C4VCO16:
            begin
                if (q.output_select == SEL_C4VCO16 && b[31])
                    rate = parent;
                else if (m == 0)
                    err = 1'b1;
                else
                begin
                    vco = (parent / m) * 64'(b[15:8]);
                    if (q.output_select == SEL_C4VCO16)
                        rate = vco;
                    else
                        rate = b[29] ? (vco >> 1) : (vco >> 2);
                end
            end
            SEL_PLLEP14: rate = parent / post_divisor(b[28:24]);
            SEL_C4P17:   rate = parent / post_divisor(b[23:19]);
            SEL_THIRD18: rate = parent / 3;
            SEL_FIFTH19: rate = parent / 5;
            default:     rate = 0;
        endcase
        if (dsh >= 0)
            rate = byp ? parent : parent / (64'((dw >> dsh) & 32'hff) / 2 + 1);
        if (err)
            rate = 0;
        if (rate > 64'hff_ffff_ffff)
            rate = 64'hff_ffff_ffff;
        r.output_rate = rate[39:0];
        r.divide_error = err;
        return r;
    endfunction

    function automatic in_word_t random_query();
        in_word_t q;
        q.output_select = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 9) == 0)
            q.output_select = 5'($urandom_range(0, 20));
        q.parent_rate = $urandom;
        q.base_word = $urandom;
        q.misc_word = $urandom;
        q.divider_word = $urandom;
        // Skew toward small M and reasonable parents
        case ($urandom_range(0, 3))
            0: q.base_word[7:0] = 8'($urandom_range(0, 3));
            1: q.parent_rate = $urandom_range(0, 100_000_000);
            default: ;
        endcase
        return q;
    endfunction

    // Fill the query queue: directed corners and cases, then random
    initial
    begin
        in_word_t q;
        logic [31:0] corners [0:3];
        corners = '{32'h0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff};
        for (int s = 0; s < 22; s++)
        begin
            q.output_select = 5'(s == 21 ? 31 : s);
            q.parent_rate = corners[s % 4];
            q.base_word = corners[(s + 1) % 4];
            q.misc_word = corners[(s + 2) % 4];
            q.divider_word = corners[(s + 3) % 4];
            pending_queries.push_back(q);
        end
        // Zero M with and without bypass
        q = '{SEL_BASE0, 32'd38_400_000, 32'h0000_0000, 32'h0, 32'h0};
        pending_queries.push_back(q);
        q.base_word = 32'h8000_0000;
        pending_queries.push_back(q);
        q = '{SEL_PLLE13, 32'hffff_ffff, 32'h2000_ff01, 32'h0, 32'h0};
        pending_queries.push_back(q);
        for (int i = 0; i < RANDOM_QUERIES; i++)
            pending_queries.push_back(random_query());
    end

    // Driver: offer queued queries with random gaps, hold until taken
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word <= '0;
            send_gap <= 0;
        end
        else if (in_valid && !in_taken)
        begin
        end
        else if (send_gap > 0)
        begin
            in_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (pending_queries.size() > 0)
        begin
            in_valid <= 1'b1;
            in_word <= pending_queries.pop_front();
            send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
        end
        else
            in_valid <= 1'b0;
    end

    // Receiver readiness: random stalls plus one long hold-off
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            take_gap <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && taken == 100)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (take_gap > 0)
        begin
            take_gap <= take_gap - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (out_valid && $urandom_range(0, 3) == 0)
                take_gap <= $urandom_range(0, 9);
        end
    end

    // Monitor: record accepted queries, check accepted results, count idle cycles
    always @(posedge clk)
    begin
        out_word_t e;
        bit        active;
        active = 1'b0;
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                expected_rates.push_back(predict_rate(in_word));
                active = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                active = 1'b1;
                taken <= taken + 1;
                if (expected_rates.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected word: rate %0d err %0d",
                                 out_word.output_rate, out_word.divide_error);
                end
                else
                begin
                    e = expected_rates.pop_front();
                    if (e !== out_word)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected rate %0d err %0d, got rate %0d err %0d",
                                     e.output_rate, e.divide_error,
                                     out_word.output_rate, out_word.divide_error);
                    end
                end
            end
            idle_cycles <= active ? 0 : idle_cycles + 1;
        end
    end

    // Reset, wait for drain, report
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        taken = 0;
        in_taken = 1'b0;
        stimulus_done = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_queries.size() == 0 && !in_valid);
        wait (expected_rates.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        stimulus_done = 1'b1;
        if (mismatches == 0 && expected_rates.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (!stimulus_done && idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end
endmodule

>>> sim.f
sv/porc_pkg.sv
sv/porc_div.sv
sv/pll_output_rate_calculator_core.sv
dv/pll_output_rate_calculator_core_tb.sv
